[design/stq_pkg.sv]
// ----------------------------------------------------------------------------
// stq_pkg
// Shared codes, state and command types for the sorted timer queue manager.
// ----------------------------------------------------------------------------
package stq_pkg;

	// command modes
	localparam logic [2:0] MODE_CREATE  = 3'd0;
	localparam logic [2:0] MODE_DESTROY = 3'd1;
	localparam logic [2:0] MODE_STOP    = 3'd2;
	localparam logic [2:0] MODE_RESTART = 3'd3;
	localparam logic [2:0] MODE_TICK    = 3'd4;

	// result status codes
	localparam logic [2:0] RES_OK       = 3'd0;
	localparam logic [2:0] RES_BAD_ID   = 3'd1;
	localparam logic [2:0] RES_NO_TIMER = 3'd2;
	localparam logic [2:0] RES_NO_FREE  = 3'd3;
	localparam logic [2:0] RES_EXPIRED  = 3'd4;

	// per-timer state codes
	localparam logic [2:0] TS_FREE      = 3'd0;
	localparam logic [2:0] TS_READY     = 3'd1;
	localparam logic [2:0] TS_RUNNING   = 3'd2;
	localparam logic [2:0] TS_STOPPED   = 3'd3;
	localparam logic [2:0] TS_TRIGGERED = 3'd4;

	localparam int CNT_W = 19;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_DEC, S_CR, S_LK, S_DA1, S_DA2, S_STOPX, S_DS1, S_DS2,
		S_RS, S_ARM0, S_ARM1, S_LINK1, S_LINK2, S_TK0, S_TK1, S_FIN, S_FIN2, S_EMIT
	} ctl_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLEAR, OP_IDLE, OP_DEC, OP_CR_POP, OP_LK, OP_DA1, OP_DA2,
		OP_STOP_IDLE, OP_DS1, OP_DS2, OP_RS, OP_ARM0, OP_ARM_STEP, OP_LINK1,
		OP_LINK2, OP_TK_HEAD, OP_TK_FIRE, OP_FIN, OP_FIN2, OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       in_valid;
		logic       clr_done;
		logic       free_empty;
		logic       run_empty;
		logic       idx_oob;
		logic       lk_fail;
		logic       running;
		logic       arm_need;
		logic       rd_next_nil;
		logic       walk_lt;
		logic       due;
		logic       fire_lim;
		logic       period_nz;
		logic       out_free;
		logic       emit_last;
	} dp_stat_t;

endpackage

[design/stq_cmd_if.sv]
// ----------------------------------------------------------------------------
// stq_cmd_if
// Command channel: valid/ready handshake with one timer command per transfer.
// ----------------------------------------------------------------------------
interface stq_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [30:0] timer_id;
	logic [31:0] delay_ticks;
	logic [31:0] period_ticks;
	logic [9:0]  queue_id;
	logic [31:0] message;
	logic [62:0] now;

	modport source (
		output valid, mode, timer_id, delay_ticks, period_ticks, queue_id, message, now,
		input  ready
	);
	modport sink (
		input  valid, mode, timer_id, delay_ticks, period_ticks, queue_id, message, now,
		output ready
	);
endinterface

[design/stq_rsp_if.sv]
// ----------------------------------------------------------------------------
// stq_rsp_if
// Result channel: valid/ready handshake with one result per transfer.
// ----------------------------------------------------------------------------
interface stq_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [30:0] result_id;
	logic        fired;
	logic [9:0]  fire_queue;
	logic [31:0] fire_message;
	logic        alarm_valid;
	logic [62:0] next_alarm;
	logic        last;

	modport source (
		output valid, status, result_id, fired, fire_queue, fire_message, alarm_valid,
			next_alarm, last,
		input  ready
	);
	modport sink (
		input  valid, status, result_id, fired, fire_queue, fire_message, alarm_valid,
			next_alarm, last,
		output ready
	);
endinterface

[design/stq_ctrl.sv]
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer for the timer queue: steps each command through list operations.
// ----------------------------------------------------------------------------
module stq_ctrl import stq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_stat_t dstat,
	output dp_cmd_t  dcmd
);

	ctl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_CLR: begin
				if (dstat.clr_done) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (dstat.in_valid) state_nx = S_DEC;
			end
			S_DEC: begin
				case (dstat.mode)
					MODE_CREATE:  state_nx = dstat.free_empty ? S_FIN : S_CR;
					MODE_DESTROY,
					MODE_STOP,
					MODE_RESTART: state_nx = dstat.idx_oob ? S_FIN : S_LK;
					MODE_TICK:    state_nx = S_TK0;
					default:      state_nx = S_FIN;
				endcase
			end
			S_CR: begin
				state_nx = dstat.arm_need ? S_ARM0 : S_FIN;
			end
			S_LK: begin
				if (dstat.lk_fail) begin
					state_nx = S_FIN;
				end else if (dstat.running) begin
					state_nx = S_DA1;
				end else if (dstat.mode == MODE_STOP) begin
					state_nx = S_STOPX;
				end else if (dstat.mode == MODE_DESTROY) begin
					state_nx = S_DS1;
				end else begin
					state_nx = S_RS;
				end
			end
			S_DA1: state_nx = S_DA2;
			S_DA2: begin
				if (dstat.mode == MODE_DESTROY) begin
					state_nx = S_DS1;
				end else if (dstat.mode == MODE_RESTART) begin
					state_nx = S_RS;
				end else begin
					state_nx = S_FIN;
				end
			end
			S_STOPX: state_nx = S_FIN;
			S_DS1:   state_nx = S_DS2;
			S_DS2:   state_nx = S_FIN;
			S_RS: begin
				state_nx = dstat.arm_need ? S_ARM0 : S_FIN;
			end
			S_ARM0: begin
				state_nx = dstat.run_empty ? S_LINK1 : S_ARM1;
			end
			S_ARM1: begin
				if (!dstat.walk_lt || dstat.rd_next_nil) state_nx = S_LINK1;
			end
			S_LINK1: state_nx = S_LINK2;
			S_LINK2: begin
				state_nx = (dstat.mode == MODE_TICK) ? S_TK0 : S_FIN;
			end
			S_TK0: begin
				state_nx = (dstat.run_empty || dstat.fire_lim) ? S_FIN : S_TK1;
			end
			S_TK1: begin
				if (!dstat.due) begin
					state_nx = S_FIN;
				end else begin
					state_nx = dstat.period_nz ? S_ARM0 : S_TK0;
				end
			end
			S_FIN:  state_nx = S_FIN2;
			S_FIN2: state_nx = S_EMIT;
			S_EMIT: begin
				if (dstat.out_free && dstat.emit_last) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// datapath command
	always_comb begin
		dcmd.op = OP_NONE;
		case (state_q)
			S_CLR:   dcmd.op = OP_CLEAR;
			S_IDLE:  dcmd.op = OP_IDLE;
			S_DEC:   dcmd.op = OP_DEC;
			S_CR:    dcmd.op = OP_CR_POP;
			S_LK:    dcmd.op = OP_LK;
			S_DA1:   dcmd.op = OP_DA1;
			S_DA2:   dcmd.op = OP_DA2;
			S_STOPX: dcmd.op = OP_STOP_IDLE;
			S_DS1:   dcmd.op = OP_DS1;
			S_DS2:   dcmd.op = OP_DS2;
			S_RS:    dcmd.op = OP_RS;
			S_ARM0:  dcmd.op = OP_ARM0;
			S_ARM1:  dcmd.op = dstat.walk_lt ? OP_ARM_STEP : OP_NONE;
			S_LINK1: dcmd.op = OP_LINK1;
			S_LINK2: dcmd.op = OP_LINK2;
			S_TK0:   dcmd.op = OP_TK_HEAD;
			S_TK1:   dcmd.op = dstat.due ? OP_TK_FIRE : OP_NONE;
			S_FIN:   dcmd.op = OP_FIN;
			S_FIN2:  dcmd.op = OP_FIN2;
			S_EMIT:  dcmd.op = OP_EMIT;
			default: dcmd.op = OP_NONE;
		endcase
	end

endmodule

[design/stq_dpath.sv]
// ----------------------------------------------------------------------------
// stq_dpath
// Timer store, free and running list pointers, fire buffer and result register.
// ----------------------------------------------------------------------------
module stq_dpath import stq_pkg::*; #(
	parameter int NUM_TIMERS         = 256,
	parameter int MAX_FIRES_PER_TICK = 63,
	parameter int ID_SEQ_SHIFT       = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	stq_cmd_if.sink      cmd,
	stq_rsp_if.source    rsp,
	input  dp_cmd_t      dcmd,
	output dp_stat_t     dstat
);

	localparam int IW     = $clog2(NUM_TIMERS);
	localparam int PW     = $clog2(NUM_TIMERS + 1);
	localparam int FIDXW  = (MAX_FIRES_PER_TICK > 1) ? $clog2(MAX_FIRES_PER_TICK) : 1;
	localparam int FCW    = $clog2(MAX_FIRES_PER_TICK + 1);
	localparam int FDEPTH = 2 ** FIDXW;
	localparam logic [PW-1:0] NIL = {PW{1'b1}};

	// timer store
	logic [30:0]   tag_mem [NUM_TIMERS];
	logic [2:0]    sts_mem [NUM_TIMERS];
	logic [63:0]   trg_mem [NUM_TIMERS];
	logic [31:0]   per_mem [NUM_TIMERS];
	logic [9:0]    que_mem [NUM_TIMERS];
	logic [31:0]   wrd_mem [NUM_TIMERS];
	logic [PW-1:0] prv_mem [NUM_TIMERS];
	logic [PW-1:0] nxt_mem [NUM_TIMERS];
	logic [41:0]   fire_mem [FDEPTH];

	logic [30:0]   rd_tag_q;
	logic [2:0]    rd_sts_q;
	logic [63:0]   rd_trg_q;
	logic [31:0]   rd_per_q;
	logic [9:0]    rd_que_q;
	logic [31:0]   rd_wrd_q;
	logic [PW-1:0] rd_prv_q;
	logic [PW-1:0] rd_nxt_q;
	logic [41:0]   fb_rd_q;

	// latched command
	logic [2:0]  mode_q;
	logic [30:0] id_q;
	logic [31:0] dly_q;
	logic [31:0] per_q;
	logic [9:0]  que_q;
	logic [31:0] msg_q;
	logic [62:0] now_q;

	logic [PW-1:0]    t_q, p_q, n_q, pred_q, walk_q;
	logic [PW-1:0]    free_head_q, free_tail_q, run_head_q;
	logic [IW-1:0]    clr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [63:0]      newtrig_q;
	logic [2:0]       st_q;
	logic [30:0]      rid_q;
	logic [FCW-1:0]   nfire_q, emit_q;
	logic             alarm_v_q;
	logic [62:0]      alarm_q;

	logic             rsp_v_q;
	logic [2:0]       rsp_status_q;
	logic [30:0]      rsp_rid_q;
	logic             rsp_fired_q;
	logic [9:0]       rsp_queue_q;
	logic [31:0]      rsp_msg_q;
	logic             rsp_alarm_v_q;
	logic [62:0]      rsp_alarm_q;
	logic             rsp_last_q;

	// write ports
	logic          tag_we, sts_we, trg_we, per_we, que_we, wrd_we, prv_we, nxt_we;
	logic [IW-1:0] tag_wa, sts_wa, trg_wa, per_wa, que_wa, wrd_wa, prv_wa, nxt_wa;
	logic [30:0]   tag_wd;
	logic [2:0]    sts_wd;
	logic [63:0]   trg_wd;
	logic [31:0]   per_wd;
	logic [9:0]    que_wd;
	logic [31:0]   wrd_wd;
	logic [PW-1:0] prv_wd, nxt_wd;
	logic [IW-1:0] raddr;
	logic          fb_we;
	logic [FCW-1:0] fb_ra;

	logic [IW-1:0]    ti;
	logic [31:0]      id_idx;
	logic [CNT_W-1:0] cnt_inc;
	logic [63:0]      rid_wide;
	logic             out_free;
	logic             take;
	logic             load;

	assign ti       = t_q[IW-1:0];
	assign id_idx   = 32'(id_q[ID_SEQ_SHIFT-1:0]);
	assign cnt_inc  = cnt_q + 1'b1;
	assign rid_wide = 64'(ti) | (64'(cnt_inc) << ID_SEQ_SHIFT);
	assign out_free = !rsp_v_q || rsp.ready;
	assign take     = (dcmd.op == OP_IDLE) && cmd.valid;
	assign load     = (dcmd.op == OP_EMIT) && out_free;

	assign cmd.ready = (dcmd.op == OP_IDLE);

	// status towards the sequencer
	assign dstat.mode        = mode_q;
	assign dstat.in_valid    = cmd.valid;
	assign dstat.clr_done    = (clr_q == IW'(NUM_TIMERS - 1));
	assign dstat.free_empty  = (free_head_q == NIL);
	assign dstat.run_empty   = (run_head_q == NIL);
	assign dstat.idx_oob     = (id_idx >= 32'(NUM_TIMERS));
	assign dstat.lk_fail     = (rd_sts_q == TS_FREE) || (rd_tag_q != id_q);
	assign dstat.running     = (rd_sts_q == TS_RUNNING);
	assign dstat.arm_need    = (dly_q != '0) || (per_q != '0);
	assign dstat.rd_next_nil = (rd_nxt_q == NIL);
	assign dstat.walk_lt     = (rd_trg_q < newtrig_q);
	assign dstat.due         = (rd_trg_q < {1'b0, now_q});
	assign dstat.fire_lim    = (nfire_q == FCW'(MAX_FIRES_PER_TICK));
	assign dstat.period_nz   = (rd_per_q != '0);
	assign dstat.out_free    = out_free;
	assign dstat.emit_last   = (emit_q == nfire_q);

	// store write and read address selection
	always_comb begin
		raddr  = ti;
		tag_we = 1'b0; tag_wa = ti; tag_wd = '0;
		sts_we = 1'b0; sts_wa = ti; sts_wd = TS_FREE;
		trg_we = 1'b0; trg_wa = ti; trg_wd = '0;
		per_we = 1'b0; per_wa = ti; per_wd = '0;
		que_we = 1'b0; que_wa = ti; que_wd = '0;
		wrd_we = 1'b0; wrd_wa = ti; wrd_wd = '0;
		prv_we = 1'b0; prv_wa = ti; prv_wd = NIL;
		nxt_we = 1'b0; nxt_wa = ti; nxt_wd = NIL;
		fb_we  = 1'b0;
		case (dcmd.op)
			OP_CLEAR: begin
				tag_we = 1'b1; tag_wa = clr_q;
				sts_we = 1'b1; sts_wa = clr_q;
				trg_we = 1'b1; trg_wa = clr_q;
				per_we = 1'b1; per_wa = clr_q;
				que_we = 1'b1; que_wa = clr_q;
				wrd_we = 1'b1; wrd_wa = clr_q;
				prv_we = 1'b1; prv_wa = clr_q;
				prv_wd = (clr_q == '0) ? NIL : PW'(clr_q) - 1'b1;
				nxt_we = 1'b1; nxt_wa = clr_q;
				nxt_wd = (clr_q == IW'(NUM_TIMERS - 1)) ? NIL : PW'(clr_q) + 1'b1;
			end
			OP_DEC: begin
				if (mode_q == MODE_CREATE) begin
					raddr = free_head_q[IW-1:0];
				end else begin
					raddr = id_idx[IW-1:0];
				end
			end
			OP_CR_POP: begin
				tag_we = 1'b1; tag_wd = rid_wide[30:0];
				sts_we = 1'b1; sts_wd = TS_READY;
				trg_we = 1'b1;
				per_we = 1'b1; per_wd = per_q;
				que_we = 1'b1; que_wd = que_q;
				wrd_we = 1'b1; wrd_wd = msg_q;
				nxt_we = 1'b1;
				// new free head loses its predecessor
				if (rd_nxt_q != NIL) begin
					prv_we = 1'b1; prv_wa = rd_nxt_q[IW-1:0];
				end
			end
			OP_DA1: begin
				if (p_q != NIL) begin
					nxt_we = 1'b1; nxt_wa = p_q[IW-1:0]; nxt_wd = n_q;
				end
				if (n_q != NIL) begin
					prv_we = 1'b1; prv_wa = n_q[IW-1:0]; prv_wd = p_q;
				end
			end
			OP_DA2: begin
				prv_we = 1'b1;
				nxt_we = 1'b1;
				sts_we = 1'b1; sts_wd = TS_STOPPED;
			end
			OP_STOP_IDLE: begin
				sts_we = 1'b1; sts_wd = TS_STOPPED;
			end
			OP_DS1: begin
				tag_we = 1'b1;
				sts_we = 1'b1; sts_wd = TS_FREE;
				trg_we = 1'b1;
				per_we = 1'b1;
				que_we = 1'b1;
				wrd_we = 1'b1;
				nxt_we = 1'b1;
				prv_we = 1'b1; prv_wd = free_tail_q;
			end
			OP_DS2: begin
				if (free_tail_q != NIL) begin
					nxt_we = 1'b1; nxt_wa = free_tail_q[IW-1:0]; nxt_wd = t_q;
				end
			end
			OP_RS: begin
				trg_we = 1'b1;
				per_we = 1'b1; per_wd = per_q;
			end
			OP_ARM0:     raddr = run_head_q[IW-1:0];
			OP_ARM_STEP: raddr = rd_nxt_q[IW-1:0];
			OP_LINK1: begin
				prv_we = 1'b1; prv_wd = pred_q;
				nxt_we = 1'b1; nxt_wd = walk_q;
				sts_we = 1'b1; sts_wd = TS_RUNNING;
				trg_we = 1'b1; trg_wd = newtrig_q;
			end
			OP_LINK2: begin
				if (pred_q != NIL) begin
					nxt_we = 1'b1; nxt_wa = pred_q[IW-1:0]; nxt_wd = t_q;
				end
				if (walk_q != NIL) begin
					prv_we = 1'b1; prv_wa = walk_q[IW-1:0]; prv_wd = t_q;
				end
			end
			OP_TK_HEAD: raddr = run_head_q[IW-1:0];
			OP_TK_FIRE: begin
				fb_we  = 1'b1;
				nxt_we = 1'b1;
				sts_we = 1'b1; sts_wd = TS_TRIGGERED;
				if (rd_nxt_q != NIL) begin
					prv_we = 1'b1; prv_wa = rd_nxt_q[IW-1:0];
				end
			end
			OP_FIN: raddr = run_head_q[IW-1:0];
			default: ;
		endcase
	end

	always_comb begin
		if (dcmd.op == OP_FIN2) begin
			fb_ra = '0;
		end else if (load) begin
			fb_ra = emit_q + 1'b1;
		end else begin
			fb_ra = emit_q;
		end
	end

	// store
	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[tag_wa] <= tag_wd;
		if (sts_we) sts_mem[sts_wa] <= sts_wd;
		if (trg_we) trg_mem[trg_wa] <= trg_wd;
		if (per_we) per_mem[per_wa] <= per_wd;
		if (que_we) que_mem[que_wa] <= que_wd;
		if (wrd_we) wrd_mem[wrd_wa] <= wrd_wd;
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		rd_tag_q <= tag_mem[raddr];
		rd_sts_q <= sts_mem[raddr];
		rd_trg_q <= trg_mem[raddr];
		rd_per_q <= per_mem[raddr];
		rd_que_q <= que_mem[raddr];
		rd_wrd_q <= wrd_mem[raddr];
		rd_prv_q <= prv_mem[raddr];
		rd_nxt_q <= nxt_mem[raddr];
	end

	// fired timers wait here until the closing alarm is known
	always_ff @(posedge clk) begin
		if (fb_we) fire_mem[nfire_q[FIDXW-1:0]] <= {rd_que_q, rd_wrd_q};
		fb_rd_q <= fire_mem[fb_ra[FIDXW-1:0]];
	end

	// list heads, creation count, clearing pass, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			free_head_q <= '0;
			free_tail_q <= PW'(NUM_TIMERS - 1);
			run_head_q  <= NIL;
			cnt_q       <= '0;
			rsp_v_q     <= 1'b0;
		end else begin
			case (dcmd.op)
				OP_CLEAR: begin
					if (clr_q != IW'(NUM_TIMERS - 1)) clr_q <= clr_q + 1'b1;
				end
				OP_CR_POP: begin
					free_head_q <= rd_nxt_q;
					if (rd_nxt_q == NIL) free_tail_q <= NIL;
					cnt_q <= cnt_inc;
				end
				OP_DA1: begin
					if (p_q == NIL) run_head_q <= n_q;
				end
				OP_DS2: begin
					if (free_tail_q == NIL) free_head_q <= t_q;
					free_tail_q <= t_q;
				end
				OP_LINK2: begin
					if (pred_q == NIL) run_head_q <= t_q;
				end
				OP_TK_FIRE: run_head_q <= rd_nxt_q;
				default: ;
			endcase
			if (load) begin
				rsp_v_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (dcmd.op)
			OP_IDLE: begin
				if (take) begin
					mode_q  <= cmd.mode;
					id_q    <= cmd.timer_id;
					dly_q   <= cmd.delay_ticks;
					per_q   <= cmd.period_ticks;
					que_q   <= cmd.queue_id;
					msg_q   <= cmd.message;
					now_q   <= cmd.now;
					st_q    <= RES_OK;
					rid_q   <= '0;
					nfire_q <= '0;
				end
			end
			OP_DEC: begin
				case (mode_q)
					MODE_CREATE: begin
						t_q <= free_head_q;
						if (free_head_q == NIL) st_q <= RES_NO_FREE;
					end
					MODE_DESTROY,
					MODE_STOP,
					MODE_RESTART: begin
						t_q <= id_idx[PW-1:0];
						if (id_idx >= 32'(NUM_TIMERS)) st_q <= RES_BAD_ID;
					end
					MODE_TICK: ;
					default: st_q <= RES_BAD_ID;
				endcase
			end
			OP_CR_POP: begin
				rid_q     <= rid_wide[30:0];
				newtrig_q <= 64'(now_q) + 64'(dly_q);
			end
			OP_LK: begin
				p_q <= rd_prv_q;
				n_q <= rd_nxt_q;
				if ((rd_sts_q == TS_FREE) || (rd_tag_q != id_q)) st_q <= RES_NO_TIMER;
			end
			OP_STOP_IDLE: st_q <= RES_EXPIRED;
			OP_RS:        newtrig_q <= 64'(now_q) + 64'(dly_q);
			OP_ARM0: begin
				pred_q <= NIL;
				walk_q <= run_head_q;
			end
			OP_ARM_STEP: begin
				pred_q <= walk_q;
				walk_q <= rd_nxt_q;
			end
			OP_TK_HEAD: t_q <= run_head_q;
			OP_TK_FIRE: begin
				nfire_q   <= nfire_q + 1'b1;
				newtrig_q <= rd_trg_q + 64'(rd_per_q);
			end
			OP_FIN2: begin
				alarm_v_q <= (run_head_q != NIL);
				if (run_head_q == NIL) begin
					alarm_q <= '0;
				end else if (rd_trg_q[63]) begin
					alarm_q <= '1;
				end else begin
					alarm_q <= rd_trg_q[62:0];
				end
				emit_q <= '0;
			end
			OP_EMIT: begin
				if (load) emit_q <= emit_q + 1'b1;
			end
			default: ;
		endcase
		if (load) begin
			rsp_alarm_v_q <= alarm_v_q;
			rsp_alarm_q   <= alarm_q;
			if (emit_q != nfire_q) begin
				rsp_status_q <= RES_OK;
				rsp_rid_q    <= '0;
				rsp_fired_q  <= 1'b1;
				rsp_queue_q  <= fb_rd_q[41:32];
				rsp_msg_q    <= fb_rd_q[31:0];
				rsp_last_q   <= 1'b0;
			end else begin
				rsp_status_q <= st_q;
				rsp_rid_q    <= rid_q;
				rsp_fired_q  <= 1'b0;
				rsp_queue_q  <= '0;
				rsp_msg_q    <= '0;
				rsp_last_q   <= 1'b1;
			end
		end
	end

	assign rsp.valid        = rsp_v_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.result_id    = rsp_rid_q;
	assign rsp.fired        = rsp_fired_q;
	assign rsp.fire_queue   = rsp_queue_q;
	assign rsp.fire_message = rsp_msg_q;
	assign rsp.alarm_valid  = rsp_alarm_v_q;
	assign rsp.next_alarm   = rsp_alarm_q;
	assign rsp.last         = rsp_last_q;

endmodule

[design/sorted_timer_queue_manager_unit.sv]
// ----------------------------------------------------------------------------
// sorted_timer_queue_manager_unit
// Pool of one-shot and periodic timers on a free list and a sorted running list.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over the timer store before it
// takes the first command. One command is handled at a time. A bad id, an
// exhausted pool or an undefined mode goes straight to the result; destroy,
// stop and restart first look the timer up and unlink it if it is running.
// A create or restart with a nonzero delay or period arms the timer in a
// sorted walk of the running list, one running timer visited per step. A
// tick fires due timers from the head of the running list and re-arms each
// periodic one with the same walk. Results then leave at one per cycle when
// the sink is ready, fired timers first and the closing result last; the
// store's single read port sets the pace of every list step.
module sorted_timer_queue_manager_unit import stq_pkg::*; #(
	parameter int NUM_TIMERS         = 256,
	parameter int MAX_FIRES_PER_TICK = 63,
	parameter int ID_SEQ_SHIFT       = 12
) (
	input  logic     clk,
	input  logic     arst_n,
	stq_cmd_if.sink  cmd,
	stq_rsp_if.source rsp
);

	dp_cmd_t  dcmd;
	dp_stat_t dstat;

	stq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.dstat  (dstat),
		.dcmd   (dcmd)
	);

	stq_dpath #(
		.NUM_TIMERS         (NUM_TIMERS),
		.MAX_FIRES_PER_TICK (MAX_FIRES_PER_TICK),
		.ID_SEQ_SHIFT       (ID_SEQ_SHIFT)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.dcmd   (dcmd),
		.dstat  (dstat)
	);

endmodule
